// ----- hdl/crc32rc_pkg.sv -----
// Shared widths, register map and CRC step function for the reflected CRC-32 block.
package crc32rc_pkg;

    localparam int DATA_W = 8;
    localparam int CRC_W  = 32;
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;

    // word index taken from paddr[ADDR_W-1:2]
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_POLYNOMIAL = '0;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'hE792_105A;

    // one byte absorbed LSB first: eight shift/xor steps
    function automatic logic [CRC_W-1:0] absorb_byte(
        input logic [CRC_W-1:0]  rem,
        input logic [DATA_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] r;
        r = rem ^ {{(CRC_W-DATA_W){1'b0}}, data};
        for (int i = 0; i < DATA_W; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ poly;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/crc32rc_if.sv -----
// Valid/ready channel interfaces: byte requests in, CRC results out.
interface crc32rc_in_if;
    logic                             valid;
    logic                             ready;
    logic [crc32rc_pkg::DATA_W-1:0]   data_byte;
    logic                             first_byte;
    logic                             last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crc32rc_out_if;
    logic                            valid;
    logic                            ready;
    logic [crc32rc_pkg::CRC_W-1:0]   crc_value;

    modport source (output valid, crc_value, input ready);
    modport sink   (input valid, crc_value, output ready);
endinterface

// ----- hdl/crc32_reflected_configurable.sv -----
// Reflected CRC-32 engine with remainder memory, forwarding and APB polynomial register.
//
// Usage:
//   byte_in carries one message byte per request, with first_byte (restart the
//   remainder at zero) and last_byte (emit a result). crc_out carries the
//   32-bit remainder after each last byte, CRC byte 0 in bits 7:0.
//   The polynomial register sits at APB word 0 (byte addresses 0 to 3); addresses
//   4 to 7 read as zero and ignore writes. Change it only while no request is in flight.
// Timing:
//   One byte per cycle while no result is held. A byte is accepted, its
//   remainder is read from the one-entry remainder memory at that edge, and
//   the eight-step update runs from the update stage; a write from the byte
//   just ahead is forwarded. A result goes from the update stage into the
//   output register, which drives crc_out.valid directly.
// Reset:
//   Remainder reads as zero until first written; polynomial is 0xE792105A.
// Stall:
//   A held result stops the next last byte in the update stage; bytes ahead
//   of it keep flowing, and byte_in.ready drops while that last byte waits.
module crc32_reflected_configurable (
    input  logic                               clk,
    input  logic                               rst_n,
    crc32rc_in_if.sink                         byte_in,
    crc32rc_out_if.source                      crc_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crc32rc_pkg::ADDR_W-1:0]     paddr,
    input  logic [crc32rc_pkg::APB_DW-1:0]     pwdata,
    output logic [crc32rc_pkg::APB_DW-1:0]     prdata,
    output logic                               pready
);

    logic [crc32rc_pkg::CRC_W-1:0]  rem_mem [0:0];

    logic [crc32rc_pkg::CRC_W-1:0]  poly_reg;
    logic                           mem_valid_reg;
    logic                           s1_valid_reg;
    logic [crc32rc_pkg::DATA_W-1:0] s1_data_reg;
    logic                           s1_first_reg;
    logic                           s1_last_reg;
    logic [crc32rc_pkg::CRC_W-1:0]  rd_data_reg;
    logic                           rd_valid_reg;
    logic                           byp_reg;
    logic [crc32rc_pkg::CRC_W-1:0]  wb_data_reg;
    logic                           out_valid_reg;
    logic [crc32rc_pkg::CRC_W-1:0]  crc_reg;

    logic                           accept;
    logic                           out_free;
    logic                           s1_adv;
    logic                           reg_hit;
    logic                           cfg_wr;
    logic [crc32rc_pkg::CRC_W-1:0]  base_rem;
    logic [crc32rc_pkg::CRC_W-1:0]  rem_next;

    assign reg_hit = (paddr[crc32rc_pkg::ADDR_W-1:2] == crc32rc_pkg::REG_POLYNOMIAL);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? poly_reg : '0;

    assign accept   = byte_in.valid && byte_in.ready;
    assign out_free = !out_valid_reg || crc_out.ready;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || s1_adv;

    assign crc_out.valid     = out_valid_reg;
    assign crc_out.crc_value = crc_reg;

    // write from the byte ahead lands at the same edge as our read
    always_comb
    begin
        if (s1_first_reg)
            base_rem = '0;
        else if (byp_reg)
            base_rem = wb_data_reg;
        else if (rd_valid_reg)
            base_rem = rd_data_reg;
        else
            base_rem = '0;
        rem_next = crc32rc_pkg::absorb_byte(base_rem, s1_data_reg, poly_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= crc32rc_pkg::POLY_RESET;
            mem_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                poly_reg <= pwdata[crc32rc_pkg::CRC_W-1:0];
            if (s1_adv)
                mem_valid_reg <= 1'b1;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= mem_valid_reg;
                byp_reg      <= s1_adv;
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (crc_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg  <= byte_in.data_byte;
            s1_first_reg <= byte_in.first_byte;
            s1_last_reg  <= byte_in.last_byte;
            rd_data_reg  <= rem_mem[0];
        end
        if (s1_adv)
        begin
            rem_mem[0]  <= rem_next;
            wb_data_reg <= rem_next;
        end
        if (s1_adv && s1_last_reg)
            crc_reg <= rem_next;
    end

endmodule

// ----- hdl/crc32rc_checker.sv -----
// Port-level checker for the reflected CRC-32 block, bound to the top level.
module crc32rc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             in_first,
    input logic                             in_last,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [crc32rc_pkg::CRC_W-1:0]    out_crc
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // results owed: accepted last bytes not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && in_last && !out_acc)
            pend_next = pend_reg + 2'd1;
        else if (out_acc && !(in_acc && in_last))
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_crc))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a last byte");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two results outstanding");

    a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_first && in_last && pend_reg == 2'd0 |-> ##2 out_valid)
        else $error("one-byte message result late");

endmodule

bind crc32_reflected_configurable crc32rc_checker u_crc32rc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_first  (byte_in.first_byte),
    .in_last   (byte_in.last_byte),
    .out_valid (crc_out.valid),
    .out_ready (crc_out.ready),
    .out_crc   (crc_out.crc_value)
);

// ----- dv/tb_crc32_reflected_configurable.sv -----
// Self-checking testbench for the reflected CRC-32 block: random byte streams, APB polynomial writes.
module tb_crc32_reflected_configurable;

    localparam int          HALF_PERIOD    = 5;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_TRIGGER   = 25;
    localparam logic [crc32rc_pkg::ADDR_W-1:0] POLY_ADDR  =
        {crc32rc_pkg::REG_POLYNOMIAL, 2'b00};
    localparam logic [crc32rc_pkg::ADDR_W-1:0] SPARE_ADDR =
        {~crc32rc_pkg::REG_POLYNOMIAL, 2'b00};

    typedef struct packed {
        logic [crc32rc_pkg::DATA_W-1:0] data_byte;
        logic                           first_byte;
        logic                           last_byte;
    } byte_req_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [crc32rc_pkg::ADDR_W-1:0] paddr;
    logic [crc32rc_pkg::APB_DW-1:0] pwdata;
    logic [crc32rc_pkg::APB_DW-1:0] prdata;
    logic                           pready;

    crc32rc_in_if  byte_if ();
    crc32rc_out_if crc_if ();

    crc32_reflected_configurable u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_if),
        .crc_out (crc_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    byte_req_t                     pending_bytes[$];
    logic [crc32rc_pkg::CRC_W-1:0] crc_expected[$];
    logic [crc32rc_pkg::CRC_W-1:0] rem_model;
    logic [crc32rc_pkg::CRC_W-1:0] poly_model;

    logic        idle_en;
    logic        in_taken;
    logic        long_hold_done;
    int unsigned long_hold_left;
    int unsigned src_gap;
    int unsigned sink_gap;
    int unsigned quiet_cycles;
    int unsigned n_pushed;
    int unsigned n_bytes_taken;
    int unsigned n_crc_seen;
    int unsigned n_poly_settings;
    int unsigned err_count;

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // one byte folded in LSB first
    function automatic logic [crc32rc_pkg::CRC_W-1:0] crc_step(
        input logic [crc32rc_pkg::CRC_W-1:0]  rem,
        input logic [crc32rc_pkg::DATA_W-1:0] data,
        input logic [crc32rc_pkg::CRC_W-1:0]  poly
    );
        logic [crc32rc_pkg::CRC_W-1:0] r;
        logic                          out_bit;
        r = rem;
        r[crc32rc_pkg::DATA_W-1:0] = r[crc32rc_pkg::DATA_W-1:0] ^ data;
        repeat (crc32rc_pkg::DATA_W)
        begin
            out_bit = r[0];
            r = r >> 1;
            if (out_bit)
                r = r ^ poly;
        end
        return r;
    endfunction

    task automatic fold_byte_request(input byte_req_t req);
        if (req.first_byte)
            rem_model = '0;
        rem_model = crc_step(rem_model, req.data_byte, poly_model);
        if (req.last_byte)
            crc_expected.push_back(rem_model);
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [crc32rc_pkg::CRC_W-1:0] got,
                                   input logic [crc32rc_pkg::CRC_W-1:0] want);
        $display("MISMATCH %s: got %08h, expected %08h (request %0d)",
                 what, got, want, n_bytes_taken);
        err_count++;
    endtask

    // mostly back to back, some short gaps, a few long ones; no gaps while idle_en is clear
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(negedge clk)
    begin : drive_bytes
        byte_req_t req;
        if (!rst_n)
            byte_if.valid <= 1'b0;
        else if (byte_if.valid && !in_taken)
        begin
            // request still waiting for ready
        end
        else if (src_gap > 0)
        begin
            byte_if.valid <= 1'b0;
            src_gap--;
        end
        else if (pending_bytes.size() > 0)
        begin
            req = pending_bytes.pop_front();
            byte_if.data_byte  <= req.data_byte;
            byte_if.first_byte <= req.first_byte;
            byte_if.last_byte  <= req.last_byte;
            byte_if.valid      <= 1'b1;
            src_gap = pick_gap();
        end
        else
            byte_if.valid <= 1'b0;
    end

    // result sink with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            crc_if.ready <= 1'b0;
        else if (!long_hold_done && n_crc_seen >= HOLD_TRIGGER)
        begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            crc_if.ready <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left--;
            crc_if.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            crc_if.ready <= 1'b0;
        end
        else
        begin
            crc_if.ready <= 1'b1;
            sink_gap = pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : watch_channels
        byte_req_t                     req;
        logic [crc32rc_pkg::CRC_W-1:0] want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= byte_if.valid && byte_if.ready;
            if (byte_if.valid && byte_if.ready)
            begin
                req.data_byte  = byte_if.data_byte;
                req.first_byte = byte_if.first_byte;
                req.last_byte  = byte_if.last_byte;
                fold_byte_request(req);
                n_bytes_taken++;
            end
            if (crc_if.valid && crc_if.ready)
            begin
                n_crc_seen++;
                if (crc_expected.size() == 0)
                    report_mismatch("unexpected crc_value", crc_if.crc_value, '0);
                else
                begin
                    want = crc_expected.pop_front();
                    if (crc_if.crc_value !== want)
                        report_mismatch("crc_value", crc_if.crc_value, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (byte_if.valid && byte_if.ready) || (crc_if.valid && crc_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_req(input logic [crc32rc_pkg::DATA_W-1:0] data, input logic first,
                            input logic last);
        byte_req_t req;
        req.data_byte  = data;
        req.first_byte = first;
        req.last_byte  = last;
        pending_bytes.push_back(req);
        n_pushed++;
    endtask

    // mostly well-formed messages, some with random flags
    task automatic queue_messages(input int unsigned n_items);
        int unsigned cnt;
        int unsigned len;
        logic        noisy;
        cnt = 0;
        while (cnt < n_items)
        begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (noisy)
                    push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0);
                else
                    push_req(8'($urandom_range(0, 255)), k == 0 && $urandom_range(0, 15) != 0,
                             k == len - 1);
                cnt++;
            end
        end
    endtask

    task automatic apb_access(input logic wr, input logic [crc32rc_pkg::ADDR_W-1:0] addr,
                              input logic [crc32rc_pkg::APB_DW-1:0] wdata,
                              output logic [crc32rc_pkg::APB_DW-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr && addr[crc32rc_pkg::ADDR_W-1:2] == crc32rc_pkg::REG_POLYNOMIAL)
            poly_model = wdata[crc32rc_pkg::CRC_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // block must be drained: results trail the last request through the update stage and output register
    task automatic wait_idle();
        while (n_bytes_taken != n_pushed || crc_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_polynomial(input logic [crc32rc_pkg::CRC_W-1:0] value,
                                  input logic poke_spare);
        logic [crc32rc_pkg::APB_DW-1:0] rd;
        wait_idle();
        apb_access(1'b1, POLY_ADDR, value, rd);
        apb_access(1'b0, POLY_ADDR, '0, rd);
        if (rd !== poly_model)
            report_mismatch("polynomial readback", rd, poly_model);
        if (poke_spare)
        begin
            // unmapped address: write ignored, reads zero
            apb_access(1'b1, SPARE_ADDR, $urandom, rd);
            apb_access(1'b0, SPARE_ADDR, '0, rd);
            if (rd !== '0)
                report_mismatch("unmapped readback", rd, '0);
            apb_access(1'b0, POLY_ADDR, '0, rd);
            if (rd !== poly_model)
                report_mismatch("polynomial after unmapped write", rd, poly_model);
        end
        n_poly_settings++;
    endtask

    initial
    begin : stimulus
        logic [crc32rc_pkg::CRC_W-1:0] poly_list[7];
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.first_byte = 1'b0;
        byte_if.last_byte  = 1'b0;
        crc_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rst_n              = 1'b0;
        idle_en            = 1'b1;
        long_hold_done     = 1'b0;
        long_hold_left     = 0;
        src_gap            = 0;
        sink_gap           = 0;
        quiet_cycles       = 0;
        n_pushed           = 0;
        n_bytes_taken      = 0;
        n_crc_seen         = 0;
        n_poly_settings    = 1;
        err_count          = 0;
        rem_model          = '0;
        poly_model         = crc32rc_pkg::POLY_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset polynomial
        push_req(8'h00, 1'b0, 1'b0);   // no first byte right after reset
        push_req(8'hFF, 1'b0, 1'b1);
        push_req(8'hA5, 1'b0, 1'b1);   // continues from the emitted remainder
        push_req(8'h00, 1'b1, 1'b1);   // one-byte messages
        push_req(8'hFF, 1'b1, 1'b1);
        push_req(8'h80, 1'b1, 1'b1);
        push_req(8'h01, 1'b1, 1'b1);
        push_req(8'h55, 1'b1, 1'b0);
        push_req(8'hAA, 1'b0, 1'b0);
        push_req(8'h7F, 1'b0, 1'b1);
        push_req(8'h12, 1'b1, 1'b0);
        push_req(8'h34, 1'b1, 1'b0);   // restart mid-message
        push_req(8'h56, 1'b0, 1'b1);
        push_req(8'h3C, 1'b1, 1'b0);   // message left open across a polynomial change

        set_polynomial(32'hEDB8_8320, 1'b1);
        push_req(8'hC3, 1'b0, 1'b1);
        queue_messages(240);

        poly_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h82F6_3B78, 32'h8000_0000,
                      32'h0000_0001, 32'h0, crc32rc_pkg::POLY_RESET};
        poly_list[5] = $urandom;
        for (int p = 0; p < 7; p++)
        begin
            set_polynomial(poly_list[p], 1'b0);
            idle_en = (p != 3);
            queue_messages(200);
        end

        wait_idle();
        if (crc_expected.size() != 0)
            report_mismatch("results never arrived", crc_expected.size(), '0);

        $display("Summary: %0d byte requests, %0d CRC results over %0d polynomial settings",
                 n_bytes_taken, n_crc_seen, n_poly_settings);
        $display("Summary: output held off %0d cycles once while bytes kept coming", LONG_HOLD);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
